>>> hdl/bcdl_pkg.sv
// ----------------------------------------------------------------------------
// bcdl_pkg
// Shared types and constants for the button code door lock.
// ----------------------------------------------------------------------------
package bcdl_pkg;

  localparam int CODE_BITS_DEFAULT = 8;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int TIME_W     = 16;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS      = 2'd0,
    REG_ENTRY_TIMEOUT_MS = 2'd1,
    REG_OPEN_TIME_MS     = 2'd2,
    REG_RESTORE_CODE     = 2'd3
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [TIME_W-1:0] DEBOUNCE_MS_RST      = 16'd250;
  localparam logic [TIME_W-1:0] ENTRY_TIMEOUT_MS_RST = 16'd15000;
  localparam logic [TIME_W-1:0] OPEN_TIME_MS_RST     = 16'd5000;
  localparam logic [7:0]        RESTORE_CODE_RST     = 8'b1111_0110;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    MODE_PRESS      = 2'd0,
    MODE_CONFIGURE  = 2'd1,
    MODE_RESET_CODE = 2'd2,
    MODE_TICK       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    LOCK_CLOSED = 2'd0,
    LOCK_OPEN   = 2'd1,
    LOCK_CONFIG = 2'd2
  } lock_state_t;

  typedef struct packed {
    logic [1:0] door_state;
    logic [7:0] entry_bits;
    logic [3:0] entry_count;
    logic       press_accepted;
  } result_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    sat_inc = (v == TIME_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> hdl/button_code_door_lock.sv
// ----------------------------------------------------------------------------
// button_code_door_lock
// Code lock driven by press, configure, reset-code and millisecond tick events.
// ----------------------------------------------------------------------------
// The result of an event is registered in res_out, or in res_skid if stalled.
// Throughput: one event per cycle while item_stall is low; the lock state
// and timers update in the same cycle, and a two-entry result buffer (output
// register plus skid) takes one more event while a result is stalled.
// Reset: synchronous; registers return to defaults, door closed, entry empty.
module button_code_door_lock #(
  parameter int CODE_BITS = bcdl_pkg::CODE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bcdl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcdl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          mode,
  input  logic                                bit_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [1:0]                          door_state,
  output logic [7:0]                          entry_bits,
  output logic [3:0]                          entry_count,
  output logic                                press_accepted
);
  import bcdl_pkg::*;

  localparam int LEN_W = $clog2(CODE_BITS + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CODE_BITS);

  // Configuration registers
  logic [TIME_W-1:0] debounce_ms;
  logic [TIME_W-1:0] entry_timeout_ms;
  logic [TIME_W-1:0] open_time_ms;
  logic [7:0]        restore_code;

  // Lock state
  logic [CODE_BITS-1:0] stored_code, stored_code_next;
  logic [CODE_BITS-1:0] entry_shift, entry_shift_next;
  logic [LEN_W-1:0]     entry_len, entry_len_next;
  lock_state_t          lock_state, lock_state_next;
  logic [TIME_W-1:0]    since_raw_press, since_raw_press_next;
  logic [TIME_W-1:0]    idle_time, idle_time_next;
  logic [TIME_W-1:0]    open_time, open_time_next;
  logic                 accepted;

  // Result buffer
  result_t res_new, res_out, res_skid;
  logic    skid_valid;

  logic item_fire, out_free;
  assign item_stall = skid_valid;
  assign item_fire  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= DEBOUNCE_MS_RST;
      entry_timeout_ms <= ENTRY_TIMEOUT_MS_RST;
      open_time_ms     <= OPEN_TIME_MS_RST;
      restore_code     <= RESTORE_CODE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE_MS:      debounce_ms      <= cfg_data;
        REG_ENTRY_TIMEOUT_MS: entry_timeout_ms <= cfg_data;
        REG_OPEN_TIME_MS:     open_time_ms     <= cfg_data;
        REG_RESTORE_CODE:     restore_code     <= cfg_data[7:0];
      endcase
    end
  end

  // Next state for one event
  always_comb begin
    logic [CODE_BITS-1:0] shifted;
    logic [LEN_W-1:0]     len_inc;
    logic [TIME_W-1:0]    idle_inc;
    logic [TIME_W-1:0]    open_inc;

    stored_code_next     = stored_code;
    entry_shift_next     = entry_shift;
    entry_len_next       = entry_len;
    lock_state_next      = lock_state;
    since_raw_press_next = since_raw_press;
    idle_time_next       = idle_time;
    open_time_next       = open_time;
    accepted             = 1'b0;

    shifted  = {entry_shift[CODE_BITS-2:0], bit_value};
    len_inc  = (entry_len < LEN_FULL) ? entry_len + 1'b1 : entry_len;
    idle_inc = sat_inc(idle_time);
    open_inc = sat_inc(open_time);

    unique case (mode_t'(mode))
      MODE_PRESS: begin
        accepted             = (since_raw_press >= debounce_ms);
        since_raw_press_next = '0;
        if (accepted) begin
          idle_time_next = '0;
          if (lock_state != LOCK_OPEN) begin
            entry_shift_next = shifted;
            entry_len_next   = len_inc;
            if (lock_state == LOCK_CONFIG && len_inc == LEN_FULL) begin
              stored_code_next = shifted;
              entry_shift_next = '0;
              entry_len_next   = '0;
              lock_state_next  = LOCK_CLOSED;
            end else if (lock_state == LOCK_CLOSED && len_inc == LEN_FULL &&
                         shifted == stored_code) begin
              lock_state_next  = LOCK_OPEN;
              open_time_next   = '0;
              entry_shift_next = '0;
              entry_len_next   = '0;
            end
          end
        end
      end
      MODE_CONFIGURE: begin
        lock_state_next  = LOCK_CONFIG;
        open_time_next   = '0;
        entry_shift_next = '0;
        entry_len_next   = '0;
        idle_time_next   = '0;
      end
      MODE_RESET_CODE: begin
        stored_code_next = CODE_BITS'(restore_code);
        idle_time_next   = '0;
      end
      MODE_TICK: begin
        since_raw_press_next = sat_inc(since_raw_press);
        if (idle_inc >= entry_timeout_ms) begin
          entry_shift_next = '0;
          entry_len_next   = '0;
          idle_time_next   = '0;
        end else begin
          idle_time_next = idle_inc;
        end
        if (lock_state == LOCK_OPEN) begin
          if (open_inc >= open_time_ms) begin
            lock_state_next = LOCK_CLOSED;
            open_time_next  = '0;
          end else begin
            open_time_next = open_inc;
          end
        end
      end
    endcase
  end

  // Result fields for the event
  always_comb begin
    logic [31:0] shift_ext;
    logic [31:0] len_ext;
    shift_ext              = 32'(entry_shift_next);
    len_ext                = 32'(entry_len_next);
    res_new.door_state     = lock_state_next;
    res_new.entry_bits     = shift_ext[7:0];
    res_new.entry_count    = len_ext[3:0];
    res_new.press_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_code     <= CODE_BITS'(RESTORE_CODE_RST);
      entry_shift     <= '0;
      entry_len       <= '0;
      lock_state      <= LOCK_CLOSED;
      since_raw_press <= '0;
      idle_time       <= '0;
      open_time       <= '0;
    end else if (item_fire) begin
      stored_code     <= stored_code_next;
      entry_shift     <= entry_shift_next;
      entry_len       <= entry_len_next;
      lock_state      <= lock_state_next;
      since_raw_press <= since_raw_press_next;
      idle_time       <= idle_time_next;
      open_time       <= open_time_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      result_valid <= skid_valid || item_fire;
      skid_valid   <= 1'b0;
    end else if (item_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_out <= skid_valid ? res_skid : res_new;
    end else if (item_fire) begin
      res_skid <= res_new;
    end
  end

  assign door_state     = res_out.door_state;
  assign entry_bits     = res_out.entry_bits;
  assign entry_count    = res_out.entry_count;
  assign press_accepted = res_out.press_accepted;

  // An open door never holds a partial entry
  a_open_entry_empty: assert property (@(posedge clk) disable iff (rst)
    lock_state == LOCK_OPEN |-> entry_len == '0 && entry_shift == '0)
    else $error("entry not empty while door open");

  // A buffered result always has one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a result while output register is empty");

  // Reset-code event loads the restore code
  a_reset_code: assert property (@(posedge clk) disable iff (rst)
    item_fire && mode == MODE_RESET_CODE |=>
      stored_code == $past(CODE_BITS'(restore_code)))
    else $error("stored code not restored");

  // Every raw press restarts the debounce count
  a_press_restart: assert property (@(posedge clk) disable iff (rst)
    item_fire && mode == MODE_PRESS |=> since_raw_press == '0)
    else $error("debounce count not restarted by press");

endmodule
